// ----- rtl/core/lpht_pkg.sv -----
// Package for the linear-probe hash table: sizes, codes, entry type and the FNV-1a hash round.
// No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;
  localparam int unsigned TableSlots = 64;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned IdxW       = $clog2(TableSlots);
  localparam int unsigned CntW       = $clog2(TableSlots + 1);
  localparam int unsigned EntryW     = 1 + 32 + ValueBits;

  localparam logic [1:0] OpPut    = 2'd0;
  localparam logic [1:0] OpGet    = 2'd1;
  localparam logic [1:0] OpRemove = 2'd2;
  localparam logic [1:0] OpFlush  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StMiss  = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  typedef struct packed {
    logic                 used;
    logic [31:0]          key;
    logic [ValueBits-1:0] value;
  } entry_t;

  // One FNV-1a round: xor a byte, multiply by the prime.
  function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
    logic [63:0] p;
    p = 64'(h ^ {24'd0, b}) * 64'd16777619;
    return p[31:0];
  endfunction
endpackage

// ----- rtl/core/lpht_if.sv -----
// Valid/ready channel interfaces for the hash table.
// No dependencies.
`timescale 1ns / 1ps
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] key;
  logic [31:0] value;
  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_value;
  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

// ----- rtl/core/linear_probe_hash_table.sv -----
// Top level of the linear-probe hash table: handshake, result register, assertions.
// Depends on lpht_pkg, lpht_if, lpht_ctrl.
`timescale 1ns / 1ps
// Linear-probing hash table of 64 slots with 32-bit keys and values. One
// transaction on req_i (put, get, get-and-remove, flush) yields exactly one
// transaction on rsp_o carrying a status and the read value. Transactions are
// handled one at a time: req_i.ready is high only while the sequencer is idle,
// is not just finishing, and no result is waiting. Hashing runs four byte
// rounds of the home-slot hash after acceptance, then each slot probed has its
// address presented to the slot memory, whose read is registered, and is then
// compared. A put that inserts writes the first empty slot met by the probe in
// the following cycle. A get-and-remove then re-places each entry of the
// cluster behind the hole: it lifts the entry, hashes its key and scans slots
// from its home for the first free one. Flush clears the occupancy bits at once,
// as they sit in flops. No clearing pass after reset.
module linear_probe_hash_table (
  input logic     clk_i,
  input logic     rst_ni,
  lpht_req_if.sink   req_i,
  lpht_rsp_if.source rsp_o
);
  import lpht_pkg::*;

  logic        busy, done;
  logic [1:0]  status;
  logic [31:0] rvalue;
  logic [CntW-1:0] count;
  logic        rsp_valid_q;
  logic [1:0]  status_q;
  logic [31:0] rvalue_q;

  // Accept only when idle, not finishing, and the result slot is free.
  assign req_i.ready = !busy && !done && !rsp_valid_q;
  logic start;
  assign start = req_i.valid && req_i.ready;

  lpht_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i(req_i.operation),
    .key_i(req_i.key), .value_i(req_i.value),
    .busy_o(busy), .done_o(done), .status_o(status), .rvalue_o(rvalue),
    .count_o(count));

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      if (done) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q <= status;
      rvalue_q <= rvalue;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = rvalue_q;

  // Count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(TableSlots)) else $error("count overflow");
  // No new transaction while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !start) else $error("accept with pending result");
  // Results only for a busy sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(busy)) else $error("spurious done");
  // Failed lookups return zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != StOk |-> rsp_o.read_value == 32'd0)
    else $error("nonzero value on failure");
endmodule

// ----- rtl/core/lpht_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/lpht_hash.sv -----
// Multi-cycle FNV-1a home-slot unit: one byte round per cycle.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
module lpht_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              key_i,
  output logic                     done_o,
  output logic [lpht_pkg::IdxW-1:0] home_o
);
  import lpht_pkg::*;
  logic [31:0] h_q, k_q;
  logic [2:0]  n_q;
  logic        busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
      h_q    <= '0;
      k_q    <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= '0;
        h_q    <= 32'd2166136261;
        k_q    <= key_i;
      end else if (busy_q) begin
        h_q <= fnv_round(h_q, k_q[7:0]);
        k_q <= k_q >> 8;
        n_q <= n_q + 3'd1;
        if (n_q == 3'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  assign home_o = h_q[IdxW-1:0];
endmodule

// ----- rtl/core/lpht_ctrl.sv -----
// Sequencer for the hash table: probe, insert, remove with cluster re-placement, flush.
// Depends on lpht_pkg, lpht_hash, lpht_ram.
`timescale 1ns / 1ps
module lpht_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] rvalue_o,
  output logic [lpht_pkg::CntW-1:0] count_o
);
  import lpht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_PROBE, S_INS, S_RP_RD, S_RP_CHK, S_RP_HASH,
    S_RP_SCAN, S_FLUSH, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0]         op_q, status_q;
  logic [31:0]        key_q, rval_q;
  logic [ValueBits-1:0] val_q;
  logic [IdxW-1:0]    idx_q, mv_q;
  logic [CntW-1:0]    cnt_q, n_q, left_q;
  entry_t             mv_e_q;
  logic               issue_q; // idx_q presented to the RAM this cycle
  logic               pend_q;  // read issued last cycle

  // memory port
  logic               we;
  logic [IdxW-1:0]    waddr, raddr;
  entry_t             wdata, rdata;
  logic               h_start, h_done;
  logic [IdxW-1:0]    h_home;
  logic [31:0]        h_key;

  lpht_hash u_hash (.clk_i, .rst_ni, .start_i(h_start), .key_i(h_key),
                    .done_o(h_done), .home_o(h_home));

  lpht_ram #(.Width(EntryW), .Depth(TableSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));

  // Valid bits live in flops; the RAM holds key and value.
  logic [TableSlots-1:0] used_q;
  entry_t rd;
  always_comb begin
    rd = rdata;
    rd.used = used_q[idx_q];
  end

  logic upd_used, upd_set, clr_all;
  logic [IdxW-1:0] upd_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) used_q <= '0;
    else if (clr_all) used_q <= '0;
    else if (upd_used) used_q[upd_idx] <= upd_set;
  end

  always_comb begin
    h_start = 1'b0; h_key = key_q;
    we = 1'b0; waddr = idx_q; wdata = '0; raddr = idx_q;
    upd_used = 1'b0; upd_set = 1'b0; upd_idx = idx_q; clr_all = 1'b0;
    case (state_q)
      S_IDLE: begin
        h_start = start_i && (op_i != OpFlush);
        h_key = key_i;
      end
      S_PROBE: begin
        if (pend_q && rd.used && rdata.key == key_q) begin
          if (op_q == OpPut) begin
            we = 1'b1; wdata = '{1'b1, key_q, val_q};
          end else if (op_q == OpRemove) begin
            upd_used = 1'b1; upd_set = 1'b0;
          end
        end
      end
      S_INS: begin
        if (pend_q && !rd.used) begin
          we = 1'b1; wdata = '{1'b1, key_q, val_q};
          upd_used = 1'b1; upd_set = 1'b1;
        end
      end
      S_RP_CHK: begin
        if (pend_q && rd.used && left_q != '0) begin
          upd_used = 1'b1; upd_set = 1'b0;
          h_start = 1'b1; h_key = rdata.key;
        end
      end
      S_RP_SCAN: begin
        if (pend_q && !rd.used) begin
          we = 1'b1; wdata = mv_e_q;
          upd_used = 1'b1; upd_set = 1'b1;
        end
      end
      S_FLUSH: clr_all = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      issue_q  <= 1'b0;
      pend_q   <= 1'b0;
      done_o   <= 1'b0;
      op_q     <= OpPut;
      status_q <= StOk;
      key_q    <= '0;
      rval_q   <= '0;
      val_q    <= '0;
      idx_q    <= '0;
      mv_q     <= '0;
      n_q      <= '0;
      left_q   <= '0;
      mv_e_q   <= '0;
    end else begin
      done_o  <= 1'b0;
      issue_q <= 1'b0;
      pend_q  <= issue_q;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q <= op_i; key_q <= key_i; val_q <= value_i[ValueBits-1:0];
            rval_q <= '0; status_q <= StMiss; n_q <= '0;
            if (op_i == OpFlush) begin
              if (cnt_q == '0) begin
                status_q <= StEmpty; state_q <= S_DONE;
              end else begin
                status_q <= StOk; state_q <= S_FLUSH;
              end
            end else if (op_i != OpPut && cnt_q == '0) begin
              status_q <= StEmpty; state_q <= S_DONE;
            end else begin
              state_q <= S_HASH;
            end
          end
        end
        S_HASH: if (h_done) begin
          idx_q <= h_home; issue_q <= 1'b1; state_q <= S_PROBE;
        end
        S_PROBE: if (pend_q) begin
          if (!rd.used) begin
            // empty slot: miss; for a put it is the first free slot from home
            if (op_q == OpPut) begin
              idx_q <= idx_q; pend_q <= 1'b1; state_q <= S_INS;
            end else state_q <= S_DONE;
          end else if (rdata.key == key_q) begin
            status_q <= StOk;
            if (op_q == OpPut) state_q <= S_DONE;
            else begin
              rval_q <= 32'(rdata.value);
              if (op_q == OpRemove) begin
                cnt_q <= cnt_q - 1'b1; left_q <= cnt_q - 1'b1;
                idx_q <= idx_q + 1'b1; issue_q <= 1'b1; state_q <= S_RP_CHK;
              end else state_q <= S_DONE;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            n_q <= n_q + 1'b1;
            issue_q <= 1'b1;
            if (op_q == OpPut) begin
              if (n_q == CntW'(TableSlots - 1)) begin
                if (cnt_q == CntW'(TableSlots)) begin
                  issue_q <= 1'b0; status_q <= StFull; state_q <= S_DONE;
                end else begin
                  // restart scan from home for the first empty slot
                  idx_q <= h_home; state_q <= S_INS;
                end
              end
            end else if (n_q + 1'b1 >= cnt_q) begin
              issue_q <= 1'b0; state_q <= S_DONE;
            end
          end
        end
        S_INS: if (pend_q) begin
          if (!rd.used) begin
            cnt_q <= cnt_q + 1'b1; status_q <= StOk; state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1; issue_q <= 1'b1;
          end
        end
        S_RP_CHK: if (pend_q) begin
          if (rd.used && left_q != '0) begin
            left_q <= left_q - 1'b1;
            mv_q <= idx_q;
            mv_e_q <= '{1'b1, rdata.key, rdata.value};
            state_q <= S_RP_HASH;
          end else state_q <= S_DONE;
        end
        S_RP_HASH: if (h_done) begin
          idx_q <= h_home; issue_q <= 1'b1; state_q <= S_RP_SCAN;
        end
        S_RP_SCAN: if (pend_q) begin
          if (!rd.used) begin
            idx_q <= mv_q + 1'b1; issue_q <= 1'b1; state_q <= S_RP_CHK;
          end else begin
            idx_q <= idx_q + 1'b1; issue_q <= 1'b1;
          end
        end
        S_FLUSH: begin
          cnt_q <= '0; state_q <= S_DONE;
        end
        S_DONE: begin
          done_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign status_o = status_q;
  assign rvalue_o = rval_q;
  assign count_o  = cnt_q;
endmodule

// ----- bench/tb_linear_probe_hash_table.sv -----
// Self-checking bench for the linear-probe hash table: directed table, table fill, then random traffic.
// Depends on lpht_pkg, lpht_if and linear_probe_hash_table.
`timescale 1ns / 1ps
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int unsigned RandomOps  = 1250;
  localparam int unsigned StallLimit = 60000;
  localparam int unsigned KeyPool    = 96;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;      // expected result written into the row
    logic [1:0]  status;
    logic [31:0] read_value;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;
  lpht_req_if req_if ();
  lpht_rsp_if rsp_if ();

  linear_probe_hash_table dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mirror of the table contents.
  bit                   mirror_used [TableSlots];
  logic [31:0]          mirror_key  [TableSlots];
  logic [ValueBits-1:0] mirror_value[TableSlots];
  int unsigned          mirror_count;

  lookup_result_t pending_results[$];
  int unsigned    mismatches;
  bit             timed_out;
  bit             stim_done;
  bit             idle_free;     // stretch with no idling on either side
  int unsigned    quiet_cycles;
  logic [31:0]    key_pool[KeyPool];

  function automatic logic [IdxW-1:0] home_slot(input logic [31:0] k);
    logic [31:0] h;
    logic [63:0] p;
    h = 32'd2166136261;
    for (int b = 0; b < 4; b++) begin
      p = 64'(h ^ {24'd0, k[8*b +: 8]}) * 64'd16777619;
      h = p[31:0];
    end
    return h[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] first_free(input logic [IdxW-1:0] start);
    logic [IdxW-1:0] i;
    i = start;
    for (int n = 0; n < TableSlots; n++) begin
      if (!mirror_used[i]) return i;
      i = i + 1'b1;
    end
    return start;
  endfunction

  // Close the hole left by a removal: lift each following cluster entry
  // and drop it into the first free slot from its own home.
  function automatic void close_hole(input logic [IdxW-1:0] hole);
    logic [IdxW-1:0]      idx;
    logic [IdxW-1:0]      dst;
    logic [31:0]          k;
    logic [ValueBits-1:0] v;
    int unsigned          left;
    idx  = hole + 1'b1;
    left = mirror_count;
    while (mirror_used[idx] && left > 0) begin
      k = mirror_key[idx];
      v = mirror_value[idx];
      left--;
      mirror_used[idx] = 1'b0;
      dst = first_free(home_slot(k));
      mirror_used[dst]  = 1'b1;
      mirror_key[dst]   = k;
      mirror_value[dst] = v;
      idx = idx + 1'b1;
    end
  endfunction

  function automatic lookup_result_t apply_op(input logic [1:0] op, input logic [31:0] k,
                                              input logic [31:0] v);
    lookup_result_t  r;
    logic [IdxW-1:0] i;
    int unsigned     probes;
    bit              hit;
    r.status     = StMiss;
    r.read_value = '0;
    case (op)
      OpPut: begin
        hit = 1'b0;
        i   = home_slot(k);
        for (int n = 0; n < TableSlots && mirror_used[i]; n++) begin
          if (mirror_key[i] == k) begin
            mirror_value[i] = v;
            hit = 1'b1;
            break;
          end
          i = i + 1'b1;
        end
        if (hit) begin
          r.status = StOk;
        end else if (mirror_count >= TableSlots) begin
          r.status = StFull;
        end else begin
          i = first_free(home_slot(k));
          mirror_used[i]  = 1'b1;
          mirror_key[i]   = k;
          mirror_value[i] = v;
          mirror_count++;
          r.status = StOk;
        end
      end
      OpGet, OpRemove: begin
        if (mirror_count == 0) begin
          r.status = StEmpty;
        end else begin
          probes = 0;
          i      = home_slot(k);
          while (mirror_used[i]) begin
            if (mirror_key[i] == k) begin
              r.read_value = mirror_value[i];
              r.status     = StOk;
              if (op == OpRemove) begin
                mirror_used[i] = 1'b0;
                mirror_count--;
                close_hole(i);
              end
              break;
            end
            i = i + 1'b1;
            probes++;
            if (probes >= mirror_count) break;
          end
        end
      end
      default: begin
        if (mirror_count == 0) begin
          r.status = StEmpty;
        end else begin
          foreach (mirror_used[s]) mirror_used[s] = 1'b0;
          mirror_count = 0;
          r.status     = StOk;
        end
      end
    endcase
    return r;
  endfunction

  // Directed rows; typed expectations only where obvious.
  stim_row_t directed[19] = '{
    '{OpGet,    32'h0000_0000, 32'h0,          1'b1, StEmpty, 32'h0},
    '{OpRemove, 32'hFFFF_FFFF, 32'h0,          1'b1, StEmpty, 32'h0},
    '{OpFlush,  32'h0,         32'h0,          1'b1, StEmpty, 32'h0},
    '{OpPut,    32'h0000_0000, 32'hFFFF_FFFF,  1'b1, StOk,    32'h0},
    '{OpGet,    32'h0000_0000, 32'h0,          1'b1, StOk,    32'hFFFF_FFFF},
    '{OpPut,    32'hFFFF_FFFF, 32'h0000_0000,  1'b1, StOk,    32'h0},
    '{OpGet,    32'hFFFF_FFFF, 32'h0,          1'b1, StOk,    32'h0},
    '{OpPut,    32'h0000_0000, 32'hA5A5_5A5A,  1'b1, StOk,    32'h0},
    '{OpGet,    32'h0000_0000, 32'h0,          1'b1, StOk,    32'hA5A5_5A5A},
    '{OpGet,    32'h1234_5678, 32'h0,          1'b1, StMiss,  32'h0},
    '{OpPut,    32'h8000_0000, 32'h8000_0001,  1'b0, StOk,    32'h0},
    '{OpPut,    32'h0000_0001, 32'h7FFF_FFFF,  1'b0, StOk,    32'h0},
    '{OpRemove, 32'h0000_0000, 32'h0,          1'b1, StOk,    32'hA5A5_5A5A},
    '{OpGet,    32'h0000_0000, 32'h0,          1'b1, StMiss,  32'h0},
    '{OpGet,    32'h8000_0000, 32'h0,          1'b0, StOk,    32'h0},
    '{OpRemove, 32'hDEAD_BEEF, 32'h0,          1'b1, StMiss,  32'h0},
    '{OpFlush,  32'h0,         32'h0,          1'b1, StOk,    32'h0},
    '{OpGet,    32'h8000_0000, 32'h0,          1'b1, StEmpty, 32'h0},
    '{OpFlush,  32'h0,         32'h0,          1'b1, StEmpty, 32'h0}
  };

  // Valid stays high after an accept; the next call either idles or
  // drives the next transaction, so valid is written once per edge.
  task automatic send_op(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v,
                         input bit typed, input lookup_result_t typed_res);
    lookup_result_t r;
    while (!idle_free && $urandom_range(99) < 18) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key       <= k;
    req_if.value     <= v;
    do @(posedge clk_i); while (!req_if.ready);
    r = apply_op(op, k, v);
    if (typed && r !== typed_res)
      $display("directed row expectation disagrees with predictor: op %0d key %h", op, k);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Fill the table to capacity, then hit it with new keys for the full status.
  task automatic fill_table();
    lookup_result_t none;
    none = '{StOk, 32'h0};
    for (int n = 0; n < TableSlots + 4; n++)
      send_op(OpPut, $urandom, $urandom, 1'b0, none);
  endtask

  // Stimulus.
  initial begin
    lookup_result_t want;
    logic [1:0]     op;
    int unsigned    pick;
    req_if.valid     = 1'b0;
    req_if.operation = OpPut;
    req_if.key       = '0;
    req_if.value     = '0;
    stim_done        = 1'b0;
    idle_free        = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[r]) begin
      want = '{directed[r].status, directed[r].read_value};
      send_op(directed[r].op, directed[r].key, directed[r].value, directed[r].typed, want);
    end
    fill_table();
    send_op(OpGet, key_pool[0], 32'h0, 1'b0, want);  // miss on a full table
    wait_drained();  // sender holds until every response is back

    for (int n = 0; n < RandomOps; n++) begin
      idle_free = (n >= 600 && n < 800);
      if (n == 1000) fill_table();
      pick = $urandom_range(99);
      if (pick < 40)      op = OpPut;
      else if (pick < 70) op = OpGet;
      else if (pick < 98) op = OpRemove;
      else                op = OpFlush;
      send_op(op, ($urandom_range(9) < 8) ? key_pool[$urandom_range(KeyPool - 1)] : $urandom,
              $urandom, 1'b0, want);
    end
    req_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Response side: random backpressure, compare against the oldest expectation.
  initial begin
    lookup_result_t exp_r;
    rsp_if.ready = 1'b0;
    mismatches   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response: status %0d value %h",
                     rsp_if.status, rsp_if.read_value);
        end else begin
          exp_r = pending_results.pop_front();
          if (rsp_if.status !== exp_r.status || rsp_if.read_value !== exp_r.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                       exp_r.status, rsp_if.status, exp_r.read_value, rsp_if.read_value);
          end
        end
      end
      rsp_if.ready <= idle_free || ($urandom_range(99) >= 18);
    end
  end

  // Watchdog: cycles without any transaction.
  initial begin
    timed_out    = 1'b0;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) timed_out = 1'b1;
    end
  end

  // End of run.
  initial begin
    wait (timed_out || (stim_done && pending_results.size() == 0));
    if (!timed_out) repeat (400) @(posedge clk_i);
    if (!timed_out && mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
